### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/anms_pkg.sv
// Shared constants and types for the adaptive box NMS block.
package anms_pkg;

  localparam int MAX_KEPT   = 256;
  localparam int COORD_BITS = 12;

  localparam int KEPT_AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W   = $clog2(MAX_KEPT + 1);

  localparam int Q_W        = 17;
  localparam int QFRAC      = 16;
  localparam int MAXB_W     = 9;
  localparam int KCNT_W     = 9;
  localparam int VERDICT_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int AREA_W = 2 * COORD_BITS;
  localparam int UNI_W  = AREA_W + 1;
  localparam int MULB_W = (UNI_W > Q_W) ? UNI_W : Q_W;
  localparam int PROD_W = Q_W + MULB_W;
  localparam int LIM_W  = (CNT_W > MAXB_W) ? CNT_W : MAXB_W;

  localparam logic [Q_W-1:0]    Q_ONE      = 17'd65536;
  localparam logic [Q_W-1:0]    Q_HALF     = 17'd32768;
  localparam logic [Q_W-1:0]    BYPASS_MIN = 17'd64881;
  localparam logic [Q_W-1:0]    IOU_RESET  = 17'd49152;
  localparam logic [Q_W-1:0]    ETA_RESET  = 17'd65536;
  localparam logic [MAXB_W-1:0] MAXB_RESET = 9'd256;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IOU = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ETA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX = 2'd2;

  // verdict codes
  localparam logic [VERDICT_W-1:0] V_KEPT       = 2'd0;
  localparam logic [VERDICT_W-1:0] V_SUPPRESSED = 2'd1;
  localparam logic [VERDICT_W-1:0] V_DROPPED    = 2'd2;
  localparam logic [VERDICT_W-1:0] V_BYPASS     = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] height;
    logic [COORD_BITS-1:0] width;
  } box_t;

  typedef struct packed {
    box_t              box;
    logic [AREA_W-1:0] area;
  } entry_t;

endpackage

### hw/rtl/anms_ifs.sv
// Request channels of the adaptive box NMS block: box input and verdict output.
interface anms_box_if;
  import anms_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  first_of_set;
  logic [COORD_BITS-1:0] box_row;
  logic [COORD_BITS-1:0] box_col;
  logic [COORD_BITS-1:0] box_height;
  logic [COORD_BITS-1:0] box_width;
  modport source (output valid, first_of_set, box_row, box_col, box_height, box_width,
                  input ready);
  modport sink (input valid, first_of_set, box_row, box_col, box_height, box_width,
                output ready);
endinterface

interface anms_res_if;
  import anms_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [KCNT_W-1:0]    kept_count;
  modport source (output valid, verdict, kept_count, input ready);
  modport sink (input valid, verdict, kept_count, output ready);
endinterface

### hw/rtl/adaptive_box_nms.sv
// Adaptive box NMS: a bypassed or dropped box goes from CHECK straight to FINISH; an empty box or
// the first kept box of a set goes through STORE (and DECAY when decay is on); any other box is
// scanned against the kept store first. One box in flight: the next request is taken the cycle
// after the verdict is loaded, and FINISH holds while the verdict register waits on its reader.
// The scan streams one kept entry per cycle through a five-stage overlap unit.
// Reset (rst, synchronous): registers to defaults, kept count zero, live threshold 49152.
`include "assert_macros.svh"

module adaptive_box_nms (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [anms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [anms_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  anms_box_if.sink                       boxes,
  anms_res_if.source                     results
);
  import anms_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_STORE,
    S_DECAY,
    S_FINISH
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. The live threshold only picks up iou_threshold
  // on a first-of-set box.
  // ---------------------------------------------------------------------------
  logic [Q_W-1:0]    iou_threshold;
  logic [Q_W-1:0]    eta_factor;
  logic [MAXB_W-1:0] max_boxes;

  always_ff @(posedge clk) begin
    if (rst) begin
      iou_threshold <= IOU_RESET;
      eta_factor    <= ETA_RESET;
      max_boxes     <= MAXB_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IOU: iou_threshold <= cfg_wr_data[Q_W-1:0];
        CFG_ETA: eta_factor    <= cfg_wr_data[Q_W-1:0];
        CFG_MAX: max_boxes     <= cfg_wr_data[MAXB_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and per-box registers
  // ---------------------------------------------------------------------------
  state_t                state;
  logic [CNT_W-1:0]      kept_total;
  logic [Q_W-1:0]        live_threshold;
  box_t                  cur;
  logic [AREA_W-1:0]     cur_area;
  logic                  cur_empty;
  logic [CNT_W-1:0]      issue_cnt;
  logic [4:0]            pipe_v;
  logic                  fail;
  logic [VERDICT_W-1:0]  pend_verdict;
  logic                  out_valid;
  logic [VERDICT_W-1:0]  out_verdict;
  logic [KCNT_W-1:0]     out_count;

  // Effective limit: smaller of max_boxes and the store depth.
  logic [LIM_W-1:0] limit;
  logic             at_limit;
  always_comb begin
    limit    = (LIM_W'(max_boxes) < LIM_W'(MAX_KEPT)) ? LIM_W'(max_boxes) : LIM_W'(MAX_KEPT);
    at_limit = LIM_W'(kept_total) >= limit;
  end

  logic issue_fire;
  logic scan_done;
  logic decay_on;
  assign issue_fire = (state == S_SCAN) && (issue_cnt != kept_total);
  assign scan_done  = (state == S_SCAN) && !issue_fire && (pipe_v == '0);
  assign decay_on   = (eta_factor < Q_ONE) && (live_threshold > Q_HALF);

  // ---------------------------------------------------------------------------
  // Kept store: one write (keep) and one registered read (scan) per cycle
  // ---------------------------------------------------------------------------
  entry_t kept_store [MAX_KEPT];
  entry_t mem_q;

  always_ff @(posedge clk) begin
    if (state == S_STORE) begin
      kept_store[kept_total[KEPT_AW-1:0]] <= '{box: cur, area: cur_area};
    end
    mem_q <= kept_store[issue_cnt[KEPT_AW-1:0]];
  end

  // ---------------------------------------------------------------------------
  // Overlap unit, one kept entry per cycle:
  //   s1 intersection extents, s2 intersection area, s3 union,
  //   s4 threshold * union (shared multiplier), then the compare.
  // ---------------------------------------------------------------------------
  logic [COORD_BITS:0]   a_rend, a_cend, b_rend, b_cend;
  logic [COORD_BITS-1:0] r0, c0;
  logic [COORD_BITS:0]   r1, c1, dh_full, dw_full;
  logic                  r_ovl, c_ovl, b_empty;

  always_comb begin
    a_rend  = {1'b0, cur.row} + {1'b0, cur.height};
    a_cend  = {1'b0, cur.col} + {1'b0, cur.width};
    b_rend  = {1'b0, mem_q.box.row} + {1'b0, mem_q.box.height};
    b_cend  = {1'b0, mem_q.box.col} + {1'b0, mem_q.box.width};
    r0      = (cur.row > mem_q.box.row) ? cur.row : mem_q.box.row;
    c0      = (cur.col > mem_q.box.col) ? cur.col : mem_q.box.col;
    r1      = (a_rend < b_rend) ? a_rend : b_rend;
    c1      = (a_cend < b_cend) ? a_cend : b_cend;
    r_ovl   = r1 > {1'b0, r0};
    c_ovl   = c1 > {1'b0, c0};
    dh_full = r1 - {1'b0, r0};
    dw_full = c1 - {1'b0, c0};
    b_empty = (mem_q.box.height == '0) || (mem_q.box.width == '0);
  end

  logic [COORD_BITS-1:0] s1_dh, s1_dw;
  logic [AREA_W-1:0]     s1_area_b, s2_area_b, s2_inter, s3_inter, s4_inter;
  logic [UNI_W-1:0]      s3_uni;
  logic                  s1_pass, s2_pass, s3_pass, s4_pass;
  logic [MULB_W-1:0]     mul_b;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     inter_q;
  logic [PROD_W-1:0]     rounded;
  logic                  ovl_fail;

  // in STORE the pipe is empty, so the multiplier takes eta for the decay
  assign mul_b = (state == S_STORE) ? MULB_W'(eta_factor) : MULB_W'(s3_uni);

  always_ff @(posedge clk) begin
    s1_dh     <= dh_full[COORD_BITS-1:0];
    s1_dw     <= dw_full[COORD_BITS-1:0];
    s1_area_b <= mem_q.area;
    s1_pass   <= b_empty || !r_ovl || !c_ovl;

    s2_inter  <= s1_dh * s1_dw;
    s2_area_b <= s1_area_b;
    s2_pass   <= s1_pass;

    s3_uni    <= UNI_W'(cur_area) + UNI_W'(s2_area_b) - UNI_W'(s2_inter);
    s3_inter  <= s2_inter;
    s3_pass   <= s2_pass;

    prod      <= live_threshold * mul_b;
    s4_inter  <= s3_inter;
    s4_pass   <= s3_pass;
  end

  assign inter_q  = PROD_W'({s4_inter, {QFRAC{1'b0}}});
  assign ovl_fail = pipe_v[4] && !s4_pass && (inter_q > prod);
  assign rounded  = prod + PROD_W'(Q_HALF);

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      kept_total     <= '0;
      live_threshold <= IOU_RESET;
      issue_cnt      <= '0;
      pipe_v         <= '0;
      fail           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      pipe_v <= {pipe_v[3:0], issue_fire};
      // FINISH reloads the register itself
      if (out_valid && results.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (boxes.valid) begin
            cur.row    <= boxes.box_row;
            cur.col    <= boxes.box_col;
            cur.height <= boxes.box_height;
            cur.width  <= boxes.box_width;
            cur_area   <= boxes.box_height * boxes.box_width;
            cur_empty  <= (boxes.box_height == '0) || (boxes.box_width == '0);
            if (boxes.first_of_set) begin
              kept_total     <= '0;
              live_threshold <= iou_threshold;
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          fail      <= 1'b0;
          issue_cnt <= '0;
          if (live_threshold >= BYPASS_MIN) begin
            pend_verdict <= V_BYPASS;
            state        <= S_FINISH;
          end else if (at_limit) begin
            pend_verdict <= V_DROPPED;
            state        <= S_FINISH;
          end else if (cur_empty || (kept_total == '0)) begin
            // an empty box overlaps nothing
            state <= S_STORE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue_fire) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (ovl_fail) begin
            fail <= 1'b1;
          end
          if (scan_done) begin
            if (fail) begin
              pend_verdict <= V_SUPPRESSED;
              state        <= S_FINISH;
            end else begin
              state <= S_STORE;
            end
          end
        end
        S_STORE: begin
          kept_total   <= kept_total + 1'b1;
          pend_verdict <= V_KEPT;
          state        <= decay_on ? S_DECAY : S_FINISH;
        end
        S_DECAY: begin
          // round to nearest, ties up
          live_threshold <= rounded[QFRAC+Q_W-1:QFRAC];
          state          <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || results.ready) begin
            out_valid   <= 1'b1;
            out_verdict <= pend_verdict;
            out_count   <= (pend_verdict == V_BYPASS) ? '0 : KCNT_W'(kept_total);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign boxes.ready        = (state == S_IDLE);
  assign results.valid      = out_valid;
  assign results.verdict    = out_verdict;
  assign results.kept_count = out_count;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_cnt_cap, kept_total <= CNT_W'(MAX_KEPT), "kept count beyond store depth")
  `ASSERT_IMPL(a_pipe_scan, pipe_v != '0, state == S_SCAN, "overlap pipe busy outside scan")
  `ASSERT_IMPL(a_store_clean, state == S_STORE, !fail, "box stored after overlap failure")
  `ASSERT_IMPL(a_byp_count, results.valid && (results.verdict == V_BYPASS),
               results.kept_count == '0, "bypass result with nonzero count")
  `ASSERT_IMPL(a_res_src, $rose(out_valid), $past(state) == S_FINISH,
               "result loaded outside finish")

endmodule

### bench/anms_verdict_check.sv
// Scoreboard for adaptive_box_nms: predicts each box verdict and compares the results.
module anms_verdict_check
  import anms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  anms_box_if                   boxes,
  anms_res_if                   results,
  output int                    fail_count,
  output int                    pending,
  output int                    seen_kept,
  output int                    seen_suppressed,
  output int                    seen_dropped,
  output int                    seen_bypass
);

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [KCNT_W-1:0]    kept_count;
  } outcome_t;

  outcome_t       outcome_q[$];
  box_t           kept_boxes[MAX_KEPT];
  int unsigned    kept_n;
  logic [Q_W-1:0] live_thr;
  logic [Q_W-1:0] iou_reg;
  logic [Q_W-1:0] eta_reg;
  logic [MAXB_W-1:0] max_reg;

  // IoU(a, b) <= thr, by cross-multiplication; empty boxes never overlap
  function automatic bit overlap_allowed(box_t a, box_t b, logic [Q_W-1:0] thr);
    longint unsigned ar1, ac1, br1, bc1, r0, r1, c0, c1, inter, uni;
    if (a.height == 0 || a.width == 0 || b.height == 0 || b.width == 0)
      return 1'b1;
    ar1 = 64'(a.row) + 64'(a.height);
    ac1 = 64'(a.col) + 64'(a.width);
    br1 = 64'(b.row) + 64'(b.height);
    bc1 = 64'(b.col) + 64'(b.width);
    r0 = (a.row > b.row) ? 64'(a.row) : 64'(b.row);
    c0 = (a.col > b.col) ? 64'(a.col) : 64'(b.col);
    r1 = (ar1 < br1) ? ar1 : br1;
    c1 = (ac1 < bc1) ? ac1 : bc1;
    if (r1 <= r0 || c1 <= c0)
      return 1'b1;
    inter = (r1 - r0) * (c1 - c0);
    uni = 64'(a.height) * 64'(a.width) + 64'(b.height) * 64'(b.width) - inter;
    return (inter * 64'd65536) <= (64'(thr) * uni);
  endfunction

  // greedy NMS step: updates the kept set and threshold, returns the verdict
  function automatic outcome_t judge_box(logic first, box_t nb);
    outcome_t    o;
    int unsigned limit;
    bit          ok;
    logic [63:0] prod;
    ok = 1'b1;
    if (first) begin
      kept_n = 0;
      live_thr = iou_reg;
    end
    if (live_thr >= BYPASS_MIN) begin
      o.verdict = V_BYPASS;
      o.kept_count = '0;
      return o;
    end
    limit = (max_reg < MAX_KEPT) ? max_reg : MAX_KEPT;
    if (kept_n >= limit) begin
      o.verdict = V_DROPPED;
    end else begin
      for (int i = 0; i < kept_n && ok; i++)
        ok = overlap_allowed(nb, kept_boxes[i], live_thr);
      if (ok) begin
        kept_boxes[kept_n] = nb;
        kept_n++;
        o.verdict = V_KEPT;
        // decay, rounded to nearest with ties up
        if (eta_reg < Q_ONE && live_thr > Q_HALF) begin
          prod = 64'(live_thr) * 64'(eta_reg) + 64'd32768;
          live_thr = prod[32:16];
        end
      end else begin
        o.verdict = V_SUPPRESSED;
      end
    end
    o.kept_count = kept_n[KCNT_W-1:0];
    return o;
  endfunction

  always @(posedge clk) begin
    box_t     nb;
    outcome_t want;
    if (rst) begin
      outcome_q.delete();
      kept_n = 0;
      iou_reg = IOU_RESET;
      eta_reg = ETA_RESET;
      max_reg = MAXB_RESET;
      live_thr = IOU_RESET;
      fail_count = 0;
      seen_kept = 0;
      seen_suppressed = 0;
      seen_dropped = 0;
      seen_bypass = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_IOU: iou_reg = cfg_wr_data[Q_W-1:0];
          CFG_ETA: eta_reg = cfg_wr_data[Q_W-1:0];
          CFG_MAX: max_reg = cfg_wr_data[MAXB_W-1:0];
          default: ;
        endcase
      end
      if (boxes.valid && boxes.ready) begin
        nb.row = boxes.box_row;
        nb.col = boxes.box_col;
        nb.height = boxes.box_height;
        nb.width = boxes.box_width;
        outcome_q.insert(outcome_q.size(), judge_box(boxes.first_of_set, nb));
      end
      if (results.valid && results.ready) begin
        if (outcome_q.size() == 0) begin
          $error("unexpected verdict %0d, kept_count %0d: no box pending",
                 results.verdict, results.kept_count);
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          if (results.verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, results.verdict);
            fail_count++;
          end
          if (results.kept_count !== want.kept_count) begin
            $error("kept_count: expected %0d, got %0d", want.kept_count, results.kept_count);
            fail_count++;
          end
          case (want.verdict)
            V_KEPT:       seen_kept++;
            V_SUPPRESSED: seen_suppressed++;
            V_DROPPED:    seen_dropped++;
            default:      seen_bypass++;
          endcase
        end
      end
    end
    pending = outcome_q.size();
  end

endmodule

### bench/tb_adaptive_box_nms.sv
// Top-level testbench for adaptive_box_nms: box stimulus, register setup and verdict.
module tb_adaptive_box_nms;
  import anms_pkg::*;

  // Slowest legal run: ~1600 boxes each scanning 256 kept entries, with gaps and stalls
  // between them; the watchdog allows several times its length.
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int BOX_TARGET  = 1550;
  // Idle time after the last verdict before touching registers or ending the run.
  localparam int SETTLE      = 20;
  localparam int DRAIN       = 300;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  anms_box_if box_ch();
  anms_res_if res_ch();

  int fail_count, pending;
  int seen_kept, seen_suppressed, seen_dropped, seen_bypass;
  int boxes_sent;
  int settings_used;
  bit box_gaps_on;

  adaptive_box_nms dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .boxes       (box_ch),
    .results     (res_ch)
  );

  anms_verdict_check verdict_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data),
    .boxes           (box_ch),
    .results         (res_ch),
    .fail_count      (fail_count),
    .pending         (pending),
    .seen_kept       (seen_kept),
    .seen_suppressed (seen_suppressed),
    .seen_dropped    (seen_dropped),
    .seen_bypass     (seen_bypass)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Box requests. Every task starts and ends at a falling edge; valid is only
  // lowered when a gap is drawn, so it never gets two assignments in one step.
  // ---------------------------------------------------------------------------
  task automatic send_box(input logic first, input box_t b);
    int gap;
    gap = box_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      box_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    box_ch.valid        <= 1'b1;
    box_ch.first_of_set <= first;
    box_ch.box_row      <= b.row;
    box_ch.box_col      <= b.col;
    box_ch.box_height   <= b.height;
    box_ch.box_width    <= b.width;
    @(posedge clk);
    while (!box_ch.ready) @(posedge clk);
    @(negedge clk);
    boxes_sent++;
  endtask

  function automatic box_t make_box(int r, int c, int h, int w);
    box_t b;
    b.row = 12'(r);
    b.col = 12'(c);
    b.height = 12'(h);
    b.width = 12'(w);
    return b;
  endfunction

  // Registers change only with the block idle: drop valid, wait for every
  // verdict, let the pipeline settle, then write all three back to back.
  task automatic program_regs(input logic [Q_W-1:0] iou, input logic [Q_W-1:0] eta,
                              input logic [MAXB_W-1:0] maxb);
    box_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_IOU;
    cfg_wr_data <= CFG_DATA_W'(iou);
    @(negedge clk);
    cfg_index   <= CFG_ETA;
    cfg_wr_data <= CFG_DATA_W'(eta);
    @(negedge clk);
    cfg_index   <= CFG_MAX;
    cfg_wr_data <= CFG_DATA_W'(maxb);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    settings_used++;
  endtask

  // A box near a cluster seed: shifted by up to about a quarter of its size, size varied a
  // little, so the IoU with the seed spans well below and above the threshold.
  // Coordinates wrap at 12 bits, which the block must handle anyway.
  function automatic box_t jitter_box(box_t base);
    box_t b;
    int   dh, dw;
    dh = int'(base.height) / 2 + 1;
    dw = int'(base.width) / 2 + 1;
    b.row    = 12'(int'(base.row) + int'($urandom_range(0, dh)) - dh / 2);
    b.col    = 12'(int'(base.col) + int'($urandom_range(0, dw)) - dw / 2);
    b.height = 12'(int'(base.height) + int'($urandom_range(0, dh / 2)) - dh / 4);
    b.width  = 12'(int'(base.width) + int'($urandom_range(0, dw / 2)) - dw / 4);
    case ($urandom_range(0, 19))
      0: b.height = '0;
      1: b.width = '0;
      default: ;
    endcase
    return b;
  endfunction

  // Well-formed set: scored boxes gathered around one to four objects.
  task automatic cluster_set(input int n, input logic fresh);
    box_t seeds[4];
    int   k;
    k = $urandom_range(1, 4);
    for (int s = 0; s < 4; s++)
      seeds[s] = make_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(1, 600), $urandom_range(1, 600));
    for (int i = 0; i < n; i++)
      send_box(i == 0 ? fresh : 1'b0, jitter_box(seeds[$urandom_range(0, k - 1)]));
  endtask

  // Disjoint boxes on a 16x16 grid of 256-pixel squares: every box is kept until
  // the limit, so long sets fill the kept store.
  task automatic grid_set(input int n, input logic fresh);
    int slot;
    for (int i = 0; i < n; i++) begin
      slot = i % 256;
      send_box(i == 0 ? fresh : 1'b0,
               make_box((slot / 16) * 256 + $urandom_range(0, 50),
                        (slot % 16) * 256 + $urandom_range(0, 50),
                        $urandom_range(1, 200), $urandom_range(1, 200)));
    end
  endtask

  // Noise: arbitrary boxes and set starts, with empty and full-size extremes.
  task automatic noise_items(input int n);
    box_t b;
    for (int i = 0; i < n; i++) begin
      b = make_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095));
      case ($urandom_range(0, 9))
        0: b.height = '0;
        1: b.width = '0;
        2: b.height = '1;
        3: begin
          b.row = '1;
          b.col = '1;
        end
        default: ;
      endcase
      send_box($urandom_range(0, 7) == 0, b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Verdict side: random stalls, calm stretches with ready held high, and two
  // long hold-offs that back the block up into its box input.
  // ---------------------------------------------------------------------------
  initial begin : verdict_sink
    int hold, taken;
    taken = 0;
    res_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (taken == 300 || taken == 1100)
        hold = 400;
      else if ((taken / 150) % 3 == 1)
        hold = 0;
      else
        hold = $urandom_range(0, 7);
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      @(negedge clk);
      taken++;
    end
  end

  // Watchdog: ends a hung run.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("adaptive_box_nms test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [Q_W-1:0]    iou, eta;
    logic [MAXB_W-1:0] maxb;
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_index           = CFG_IOU;
    cfg_wr_data         = '0;
    box_ch.valid        = 1'b0;
    box_ch.first_of_set = 1'b0;
    box_ch.box_row      = '0;
    box_ch.box_col      = '0;
    box_ch.box_height   = '0;
    box_ch.box_width    = '0;
    boxes_sent          = 0;
    settings_used       = 0;
    box_gaps_on         = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed, reset registers (threshold 0.75, no decay, 256 boxes) ---
    send_box(1'b1, make_box(0, 0, 4095, 4095));        // full frame: kept
    send_box(1'b0, make_box(0, 0, 4095, 4095));        // identical: suppressed
    send_box(1'b0, make_box(4095, 4095, 4095, 4095));  // touches corner only: kept
    send_box(1'b0, make_box(5, 5, 0, 300));            // empty height: kept
    send_box(1'b0, make_box(0, 0, 300, 0));            // empty width: kept
    send_box(1'b0, make_box(10, 10, 100, 100));        // tiny overlap with frame: kept
    send_box(1'b0, make_box(10, 10, 100, 100));        // duplicate: suppressed
    send_box(1'b0, make_box(10, 60, 100, 100));        // IoU 1/3: kept
    // IoU exactly at threshold passes; just above fails
    send_box(1'b1, make_box(1000, 1000, 100, 100));
    send_box(1'b0, make_box(1000, 1000, 100, 75));     // IoU 0.75: kept
    send_box(1'b0, make_box(1000, 1000, 100, 74));     // vs previous 74/75: suppressed

    // threshold written mid-set stays unused until the next set start
    program_regs(17'd64881, ETA_RESET, MAXB_RESET);
    send_box(1'b0, make_box(1000, 1000, 100, 100));    // still 0.75: suppressed
    send_box(1'b1, make_box(1000, 1000, 100, 100));    // now bypass

    // limit of zero drops everything that is not bypassed
    program_regs(17'd64880, 17'd0, 9'd0);
    send_box(1'b1, make_box(200, 200, 50, 50));

    // decay with rounding, then the limit of two
    program_regs(17'd64880, 17'd52429, 9'd2);
    send_box(1'b1, make_box(200, 200, 50, 50));
    send_box(1'b0, make_box(200, 240, 50, 50));
    send_box(1'b0, make_box(3000, 3000, 50, 50));

    // threshold of exactly 1.0 and out-of-range register values
    program_regs(Q_ONE, 17'd65535, 9'd1);
    send_box(1'b1, make_box(7, 7, 7, 7));
    program_regs('1, '1, '1);
    send_box(1'b1, make_box(4095, 0, 1, 4095));
    send_box(1'b0, make_box(4095, 0, 1, 4095));

    // --- random phases, each under one register setting ---
    while (boxes_sent < BOX_TARGET) begin
      // fill the kept store to the limit twice, once with an out-of-range max
      if (settings_used == 8 || settings_used == 20) begin
        program_regs(IOU_RESET, ETA_RESET, settings_used == 8 ? MAXB_RESET : 9'd511);
        box_gaps_on = 1'b0;
        grid_set(260, 1'b1);
      end
      case ($urandom_range(0, 13))
        0: iou = '0;
        1: iou = 17'd1;
        2: iou = Q_HALF;
        3: iou = IOU_RESET;
        4: iou = 17'd64880;
        5: iou = BYPASS_MIN;
        6: iou = Q_ONE;
        7: iou = '1;
        default: iou = 17'($urandom_range(16384, 64880));
      endcase
      case ($urandom_range(0, 9))
        0: eta = '0;
        1: eta = 17'd65535;
        2: eta = Q_ONE;
        3: eta = '1;
        4: eta = Q_HALF;
        default: eta = 17'($urandom_range(45000, 65535));
      endcase
      case ($urandom_range(0, 11))
        0: maxb = '0;
        1: maxb = 9'd1;
        2: maxb = 9'd255;
        3: maxb = MAXB_RESET;
        4: maxb = '1;
        default: maxb = 9'($urandom_range(2, 40));
      endcase
      program_regs(iou, eta, maxb);
      box_gaps_on = ($urandom_range(0, 3) != 0);
      // the first set of a phase sometimes continues the old set
      for (int s = 0, n_sets = $urandom_range(1, 4); s < n_sets; s++) begin
        case ($urandom_range(0, 9))
          0, 1: noise_items($urandom_range(3, 15));
          2, 3: grid_set($urandom_range(3, 30), s != 0 || $urandom_range(0, 3) != 0);
          default: cluster_set($urandom_range(4, 40), s != 0 || $urandom_range(0, 3) != 0);
        endcase
      end
    end

    // --- drain and verdict ---
    box_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    $display("Ran %0d boxes under %0d register settings, with stalls and long hold-offs.",
             boxes_sent, settings_used);
    $display("Verdicts: %0d kept, %0d suppressed, %0d dropped at limit, %0d bypassed.",
             seen_kept, seen_suppressed, seen_dropped, seen_bypass);
    if (fail_count == 0)
      $display("adaptive_box_nms test passed");
    else
      $display("adaptive_box_nms test failed");
    $finish;
  end

endmodule
